FILE: sv/cds_pkg.sv
// Shared types, opcodes and the month length table for the calendar date stepper.
// No dependencies; every other file imports this package.
package cds_pkg;

   localparam logic [3:0]  MonthsPerYear = 4'd12;
   localparam logic [4:0]  LongMonthDays = 5'd31;
   localparam logic [15:0] ResetYear     = 16'd2000;
   // ceil(2^19 / 12): quotient by 12 is exact for dividends below 2^17
   localparam logic [15:0] RecipTwelve   = 16'd43691;
   localparam int          RecipShift    = 19;

   typedef enum logic [2:0] {
      OP_LOAD      = 3'd0,
      OP_ADD_YEARS = 3'd1,
      OP_ADD_MONTH = 3'd2,
      OP_ADD_DAYS  = 3'd3,
      OP_DAY_BACK  = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [15:0] amount;
      logic [4:0]         load_day;
      logic [3:0]         load_month;
      logic [15:0]        load_year;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  cur_day;
      logic [3:0]  cur_month;
      logic [15:0] cur_year;
   } rsp_item_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_ADD_YEAR,
      DP_DAY_BACK,
      DP_MON_MUL,
      DP_MON_APPLY,
      DP_CNT_LOAD,
      DP_DAY_STEP
   } dp_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_NEG,
      JMP_CNT_GT1
   } jmp_type;

   typedef struct packed {
      dp_op_type  dp_op;
      jmp_type    jmp;
      logic [2:0] target;
      logic       fin;
   } uword_type;

   // sequencer to datapath
   typedef struct packed {
      dp_op_type dp_op;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic neg;
      logic cnt_gt1;
   } status_type;

   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2:    len = 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = LongMonthDays;
      endcase
      return len;
   endfunction

endpackage

FILE: sv/cds_sequencer.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on cds_pkg.
module cds_sequencer
   import cds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] operation,
   input  status_type status,
   input  logic       rsp_free,
   output ctrl_type   ctrl,
   output logic       busy,
   output logic       capture
);

   localparam logic [2:0] UaLoad    = 3'd0;
   localparam logic [2:0] UaYear    = 3'd1;
   localparam logic [2:0] UaBack    = 3'd2;
   localparam logic [2:0] UaMonMul  = 3'd3;
   localparam logic [2:0] UaMonApp  = 3'd4;
   localparam logic [2:0] UaDayLoad = 3'd5;
   localparam logic [2:0] UaDayStep = 3'd6;
   localparam logic [2:0] UaFin     = 3'd7;

   logic       busy_ff, busy_in;
   logic [2:0] pc_ff, pc_in;
   uword_type  uw;
   logic       hit;
   logic [2:0] entry;

   // control store
   always_comb begin
      case (pc_ff)
         UaLoad:    uw = '{DP_LOAD,      JMP_ALWAYS,  UaFin,     1'b0};
         UaYear:    uw = '{DP_ADD_YEAR,  JMP_ALWAYS,  UaFin,     1'b0};
         UaBack:    uw = '{DP_DAY_BACK,  JMP_ALWAYS,  UaFin,     1'b0};
         UaMonMul:  uw = '{DP_MON_MUL,   JMP_NEG,     UaFin,     1'b0};
         UaMonApp:  uw = '{DP_MON_APPLY, JMP_ALWAYS,  UaFin,     1'b0};
         UaDayLoad: uw = '{DP_CNT_LOAD,  JMP_NEG,     UaFin,     1'b0};
         UaDayStep: uw = '{DP_DAY_STEP,  JMP_CNT_GT1, UaDayStep, 1'b0};
         default:   uw = '{DP_NOP,       JMP_NEXT,    UaFin,     1'b1};
      endcase
   end

   // dispatch on the item's opcode; unused codes go straight to the result step
   always_comb begin
      case (operation)
         OP_LOAD:      entry = UaLoad;
         OP_ADD_YEARS: entry = UaYear;
         OP_ADD_MONTH: entry = UaMonMul;
         OP_ADD_DAYS:  entry = UaDayLoad;
         OP_DAY_BACK:  entry = UaBack;
         default:      entry = UaFin;
      endcase
   end

   always_comb begin
      case (uw.jmp)
         JMP_ALWAYS:  hit = 1'b1;
         JMP_NEG:     hit = status.neg;
         JMP_CNT_GT1: hit = status.cnt_gt1;
         default:     hit = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      capture = 1'b0;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = entry;
         end
      end else if (uw.fin) begin
         // hold until the result register can take the item
         if (rsp_free) begin
            busy_in = 1'b0;
            capture = 1'b1;
         end
      end else begin
         pc_in = hit ? uw.target : pc_ff + 3'd1;
      end
      ctrl.dp_op = busy_ff ? uw.dp_op : DP_NOP;
      busy       = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= UaFin;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

FILE: sv/cds_datapath.sv
// Date registers and the arithmetic that the control words select.
// Depends on cds_pkg.
module cds_datapath
   import cds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_type     ctrl,
   input  req_item_type item,
   output status_type   status,
   output rsp_item_type date
);

   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [15:0] year_ff, year_in;
   logic [14:0] cnt_ff, cnt_in;
   logic [15:0] total_ff, total_in;
   logic [31:0] prod_ff, prod_in;

   logic [3:0]  ld_month;
   logic [4:0]  ld_len;
   logic [4:0]  ld_day;
   logic [4:0]  cur_len;
   logic [4:0]  prev_len;
   logic [12:0] quot;
   logic [15:0] rem;

   always_comb begin
      ld_month = (item.load_month == 4'd0) ? 4'd1 :
                 (item.load_month > MonthsPerYear) ? MonthsPerYear : item.load_month;
      ld_len   = month_len(ld_month);
      ld_day   = (item.load_day == 5'd0) ? 5'd1 :
                 (item.load_day > ld_len) ? ld_len : item.load_day;
      cur_len  = month_len(month_ff);
      prev_len = month_len(month_ff - 4'd1);
      quot     = prod_ff[31:RecipShift];
      rem      = total_ff - ({3'd0, quot} << 3) - ({3'd0, quot} << 2);
   end

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      cnt_in   = cnt_ff;
      total_in = total_ff;
      prod_in  = prod_ff;
      case (ctrl.dp_op)
         DP_LOAD: begin
            day_in   = ld_day;
            month_in = ld_month;
            year_in  = item.load_year;
         end
         DP_ADD_YEAR: begin
            year_in = year_ff + item.amount;
         end
         DP_DAY_BACK: begin
            if (day_ff <= 5'd1) begin
               if (month_ff <= 4'd1) begin
                  month_in = MonthsPerYear;
                  day_in   = LongMonthDays;
                  year_in  = year_ff - 16'd1;
               end else begin
                  month_in = month_ff - 4'd1;
                  day_in   = prev_len;
               end
            end else begin
               day_in = day_ff - 5'd1;
            end
         end
         DP_MON_MUL: begin
            // month is always 1..12, amount non-negative when this result is used
            total_in = {12'd0, month_ff - 4'd1} + item.amount;
            prod_in  = {16'd0, total_in} * {16'd0, RecipTwelve};
         end
         DP_MON_APPLY: begin
            month_in = rem[3:0] + 4'd1;
            year_in  = year_ff + {3'd0, quot};
         end
         DP_CNT_LOAD: begin
            cnt_in = item.amount[14:0];
         end
         DP_DAY_STEP: begin
            if (cnt_ff != 15'd0) begin
               cnt_in = cnt_ff - 15'd1;
               // a day at or past the month end rolls to the 1st
               if (day_ff >= cur_len) begin
                  day_in = 5'd1;
                  if (month_ff >= MonthsPerYear) begin
                     month_in = 4'd1;
                     year_in  = year_ff + 16'd1;
                  end else begin
                     month_in = month_ff + 4'd1;
                  end
               end else begin
                  day_in = day_ff + 5'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= 5'd1;
         month_ff <= 4'd1;
         year_ff  <= ResetYear;
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      total_ff <= total_in;
      prod_ff  <= prod_in;
   end

   assign status.neg     = item.amount[15];
   assign status.cnt_gt1 = cnt_ff > 15'd1;
   assign date.cur_day   = day_ff;
   assign date.cur_month = month_ff;
   assign date.cur_year  = year_ff;

endmodule

FILE: sv/calendar_date_stepper.sv
// Calendar date stepper: one item at a time, the result register frees the input side.
// Per item: unused codes go straight to the result step; load, add years and step back
// run their datapath word; add months multiplies, then applies; add N days loads a count
// and steps day by day; both skip on a negative amount. Capture waits for a free result.
// Synchronous active-high reset sets the date to 1.1.2000 and empties the result register.
// Depends on cds_pkg, cds_sequencer and cds_datapath.
module calendar_date_stepper
   import cds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   req_item_type item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   logic         accept;
   logic         busy;
   logic         capture;
   logic         rsp_free;
   ctrl_type     ctrl;
   status_type   status;
   rsp_item_type date;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   cds_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .operation (req_item.operation),
      .status    (status),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl),
      .busy      (busy),
      .capture   (capture)
   );

   cds_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item_ff),
      .status (status),
      .date   (date)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (capture) begin
         rsp_item_ff <= date;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (capture) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input side not busy after accepting an item");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.cur_month >= 4'd1 && rsp_item.cur_month <= MonthsPerYear))
      else $error("result month out of range");

   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.cur_day != 5'd0))
      else $error("result day is zero");

   a_capture_when_free: assert property (@(posedge clock) disable iff (reset)
      capture |-> rsp_free)
      else $error("result captured over an untaken item");
`endif

endmodule
